// ===== sv/dsps_pkg.sv =====
// Shared types and constants of the deadband stepper position servo.
// Used by dsps_apb_regs, dsps_classify, dsps_core and the top level.
package dsps_pkg;

    // Command field width and full-scale command (100 percent in Q7.8)
    localparam int CMD_W = 15;
    localparam logic [CMD_W-1:0] FULL_Q8 = 15'd25600;

    // Deadband of 2 percent in Q7.8 is 512, a shift by nine
    localparam int DEADBAND_SHIFT = 9;

    // Configuration port geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_POSITION_MIN    = 3'd0,
        REG_POSITION_MAX    = 3'd1,
        REG_LIMIT_MIN       = 3'd2,
        REG_LIMIT_MAX       = 3'd3,
        REG_DIRECTION_INVERT = 3'd4
    } reg_idx_t;

    // Error class against the deadband
    typedef enum logic [1:0] {
        CLS_HOLD = 2'd0,
        CLS_FWD  = 2'd1,
        CLS_REV  = 2'd2
    } cls_t;

    // Result item, step_pulse in the lowest bit
    typedef struct packed {
        logic move_done;
        logic driver_enable;
        logic direction_level;
        logic step_pulse;
    } result_t;

    localparam int RESULT_W = 4;

endpackage

// ===== sv/stepper_deadband_position_servo_top.sv =====
// Top level of the deadband bang-bang stepper position servo.
// Depends on dsps_pkg, dsps_apb_regs and dsps_core.
//
//   port group | direction | carries
//   -----------+-----------+------------------------------------------------
//   s_*        | in        | tick: start flag, command percent, lever sample
//   m_*        | out       | step pulse, direction, enable, move done
//   p*         | in/out    | APB register access
//
// One tick is accepted per cycle while s_tready is high; its result goes from
// the input register through the classifier multiplier into the result
// register and is then presented on m_*.
// s_tready drops only while both registers hold a tick and m_tready is low.
// Reset is synchronous on aresetn low and clears the move state and both
// valid flags.
module stepper_deadband_position_servo_top #(
    parameter int POSITION_BITS  = 12,
    parameter int REFRESH_PERIOD = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // start_req
    input  logic                        s_tuser,
    // [14:0] commanded_percent, [POSITION_BITS+14:15] position, zero fill
    input  logic [((dsps_pkg::CMD_W + POSITION_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [0] step_pulse, [1] direction_level, [2] driver_enable, [3] move_done
    output logic [7:0]                  m_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dsps_pkg::ADDR_W-1:0] paddr,
    input  logic [dsps_pkg::DATA_W-1:0] pwdata,
    output logic [dsps_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import dsps_pkg::*;

    logic [POSITION_BITS-1:0] position_min, position_max;
    logic [POSITION_BITS-1:0] limit_min, limit_max;
    logic                     direction_invert;
    result_t                  result;

    dsps_apb_regs #(
        .POSITION_BITS(POSITION_BITS)
    ) u_regs (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .position_min     (position_min),
        .position_max     (position_max),
        .limit_min        (limit_min),
        .limit_max        (limit_max),
        .direction_invert (direction_invert)
    );

    dsps_core #(
        .POSITION_BITS  (POSITION_BITS),
        .REFRESH_PERIOD (REFRESH_PERIOD)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_start         (s_tuser),
        .in_cmd           (s_tdata[CMD_W-1:0]),
        .in_pos           (s_tdata[CMD_W+POSITION_BITS-1:CMD_W]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_result       (result),
        .position_min     (position_min),
        .position_max     (position_max),
        .limit_min        (limit_min),
        .limit_max        (limit_max),
        .direction_invert (direction_invert)
    );

    // Pack the result flags, step_pulse lowest
    assign m_tdata = {(8 - RESULT_W)'(0), result};

endmodule

// ===== sv/dsps_apb_regs.sv =====
// APB configuration registers of the stepper position servo.
// Depends on dsps_pkg for register indexes and port widths.
module dsps_apb_regs #(
    parameter int POSITION_BITS = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dsps_pkg::ADDR_W-1:0] paddr,
    input  logic [dsps_pkg::DATA_W-1:0] pwdata,
    output logic [dsps_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output logic [POSITION_BITS-1:0]    position_min,
    output logic [POSITION_BITS-1:0]    position_max,
    output logic [POSITION_BITS-1:0]    limit_min,
    output logic [POSITION_BITS-1:0]    limit_max,
    output logic                        direction_invert
);
    import dsps_pkg::*;

    logic [POSITION_BITS-1:0] position_min_reg, position_max_reg;
    logic [POSITION_BITS-1:0] limit_min_reg, limit_max_reg;
    logic                     direction_invert_reg;
    logic                     wr_en;
    logic [2:0]               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[ADDR_W-1:2];

    // Write the addressed register at the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_min_reg     <= '0;
            position_max_reg     <= '1;
            limit_min_reg        <= '0;
            limit_max_reg        <= '1;
            direction_invert_reg <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_POSITION_MIN:     position_min_reg <= pwdata[POSITION_BITS-1:0];
                REG_POSITION_MAX:     position_max_reg <= pwdata[POSITION_BITS-1:0];
                REG_LIMIT_MIN:        limit_min_reg    <= pwdata[POSITION_BITS-1:0];
                REG_LIMIT_MAX:        limit_max_reg    <= pwdata[POSITION_BITS-1:0];
                REG_DIRECTION_INVERT: direction_invert_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_sel)
            REG_POSITION_MIN:     prdata = DATA_W'(position_min_reg);
            REG_POSITION_MAX:     prdata = DATA_W'(position_max_reg);
            REG_LIMIT_MIN:        prdata = DATA_W'(limit_min_reg);
            REG_LIMIT_MAX:        prdata = DATA_W'(limit_max_reg);
            REG_DIRECTION_INVERT: prdata = DATA_W'(direction_invert_reg);
            default:              prdata = '0;
        endcase
    end

    assign position_min     = position_min_reg;
    assign position_max     = position_max_reg;
    assign limit_min        = limit_min_reg;
    assign limit_max        = limit_max_reg;
    assign direction_invert = direction_invert_reg;

endmodule

// ===== sv/dsps_classify.sv =====
// Error classifier: compares command against lever percent by cross-multiplication.
// Depends on dsps_pkg for the full-scale constant, deadband shift and class codes.
module dsps_classify #(
    parameter int POSITION_BITS = 12
) (
    input  logic [dsps_pkg::CMD_W-1:0] target,
    input  logic [POSITION_BITS-1:0]   position,
    input  logic [POSITION_BITS-1:0]   position_min,
    input  logic [POSITION_BITS-1:0]   position_max,
    output dsps_pkg::cls_t             cls
);
    import dsps_pkg::*;

    localparam int PW = POSITION_BITS + CMD_W;
    localparam int W  = PW + 2;

    logic [POSITION_BITS-1:0] num, den;
    logic [PW-1:0]            prod, full_scaled;
    logic signed [W-1:0]      diff, band;

    // Pick the lever fraction num/den, clamped to 0..1
    always_comb begin
        priority if (position > position_max) begin
            num = POSITION_BITS'(1);
            den = POSITION_BITS'(1);
        end else if (position > position_min) begin
            num = position - position_min;
            den = position_max - position_min;
        end else begin
            num = '0;
            den = POSITION_BITS'(1);
        end
    end

    // Cross-multiply: target*den against full scale*num
    assign prod        = PW'(target) * PW'(den);
    assign full_scaled = PW'(num) * PW'(FULL_Q8);
    assign diff        = $signed(W'(prod)) - $signed(W'(full_scaled));
    assign band        = $signed(W'(den) << DEADBAND_SHIFT);

    // Classify against the deadband on each side
    always_comb begin
        priority if (diff > band)
            cls = CLS_FWD;
        else if (diff < -band)
            cls = CLS_REV;
        else
            cls = CLS_HOLD;
    end

endmodule

// ===== sv/dsps_core.sv =====
// Servo core: input register, move state and result register with stream handshake.
// Depends on dsps_pkg and dsps_classify.
module dsps_core #(
    parameter int POSITION_BITS  = 12,
    parameter int REFRESH_PERIOD = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_start,
    input  logic [dsps_pkg::CMD_W-1:0]  in_cmd,
    input  logic [POSITION_BITS-1:0]    in_pos,
    output logic                        out_valid,
    input  logic                        out_ready,
    output dsps_pkg::result_t           out_result,
    input  logic [POSITION_BITS-1:0]    position_min,
    input  logic [POSITION_BITS-1:0]    position_max,
    input  logic [POSITION_BITS-1:0]    limit_min,
    input  logic [POSITION_BITS-1:0]    limit_max,
    input  logic                        direction_invert
);
    import dsps_pkg::*;

    localparam int TICK_W = $clog2(REFRESH_PERIOD + 1);
    localparam logic [TICK_W-1:0] TICK_ONE = TICK_W'(1);
    localparam logic [TICK_W-1:0] TICK_END = TICK_W'(REFRESH_PERIOD);

    // Input register
    logic                     in_valid_reg, in_valid_next;
    logic                     start_reg;
    logic [CMD_W-1:0]         cmd_reg;
    logic [POSITION_BITS-1:0] pos_reg;

    // Result register
    logic    out_valid_reg, out_valid_next;
    result_t result_reg, result_next;

    // Move state
    logic              active_reg, active_next;
    logic              forward_reg, forward_next;
    logic [CMD_W-1:0]  held_target_reg, held_target_next;
    cls_t              error_class_reg, error_class_next;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;

    logic             in_fire, advance;
    logic [CMD_W-1:0] cmd_sat, target;
    cls_t             cls;

    // Handshake: input stage empties into the result register when it is free
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_result = result_reg;

    assign cmd_sat = (cmd_reg > FULL_Q8) ? FULL_Q8 : cmd_reg;
    assign target  = start_reg ? cmd_sat : held_target_reg;

    dsps_classify #(
        .POSITION_BITS(POSITION_BITS)
    ) u_classify (
        .target       (target),
        .position     (pos_reg),
        .position_min (position_min),
        .position_max (position_max),
        .cls          (cls)
    );

    // Step one tick of the servo
    always_comb begin
        logic              act0, fwd0, done0, refresh, ok;
        cls_t              ec0, ec1;
        logic [TICK_W-1:0] tc0;

        act0  = active_reg;
        fwd0  = forward_reg;
        ec0   = error_class_reg;
        tc0   = tick_count_reg;
        done0 = 1'b0;
        ok    = 1'b0;
        refresh = 1'b0;

        held_target_next = held_target_reg;
        active_next      = active_reg;
        forward_next     = forward_reg;
        error_class_next = error_class_reg;
        tick_count_next  = tick_count_reg;
        result_next      = result_reg;

        // Start a move, or refuse it
        if (start_reg) begin
            ec0 = cls;
            tc0 = TICK_ONE;
            priority if (cls == CLS_FWD && pos_reg <= limit_max) begin
                fwd0 = 1'b1;
                act0 = 1'b1;
            end else if (cls == CLS_REV && pos_reg >= limit_min) begin
                fwd0 = 1'b0;
                act0 = 1'b1;
            end else begin
                act0  = 1'b0;
                done0 = 1'b1;
            end
        end
        ec1 = ec0;

        // Run the move: refresh the error on the period, step while clear
        if (act0) begin
            refresh = (tc0 >= TICK_END);
            ec1 = refresh ? cls : ec0;
            if (fwd0)
                ok = (ec1 == CLS_FWD) && (pos_reg <= limit_max);
            else
                ok = (ec1 == CLS_REV) && (pos_reg > limit_min);
            tc0 = refresh ? TICK_ONE : tc0 + TICK_ONE;
        end

        if (advance) begin
            held_target_next = target;
            active_next      = act0 && ok;
            forward_next     = fwd0;
            error_class_next = ec1;
            tick_count_next  = tc0;
            result_next.step_pulse      = act0 && ok;
            result_next.direction_level = fwd0 ? direction_invert : !direction_invert;
            result_next.driver_enable   = act0 && ok;
            result_next.move_done       = done0 || (act0 && !ok);
        end
    end

    assign in_valid_next  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            active_reg      <= 1'b0;
            forward_reg     <= 1'b0;
            held_target_reg <= '0;
            error_class_reg <= CLS_HOLD;
            tick_count_reg  <= TICK_ONE;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            active_reg      <= active_next;
            forward_reg     <= forward_next;
            held_target_reg <= held_target_next;
            error_class_reg <= error_class_next;
            tick_count_reg  <= tick_count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            start_reg <= in_start;
            cmd_reg   <= in_cmd;
            pos_reg   <= in_pos;
        end
        result_reg <= result_next;
    end

endmodule
